>>> rtl/core/bcrc_pkg.sv
// bcrc_pkg: constants, types and the crc byte fold for the per-block crc-32 core
// no dependencies; imported by every module in rtl/core
package bcrc_pkg;

  localparam int BLOCK_BYTES = 2048;
  localparam int POS_W       = $clog2(BLOCK_BYTES + 1);
  localparam int PAD_W       = 11;
  localparam int BLK_W       = 16;
  localparam int CRC_W       = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int Q_AW        = $clog2(QUEUE_DEPTH);

  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;
  localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFFFFFF;
  localparam logic [31:0]      PAD_MAX  = 32'd2047;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_out_t;

  typedef enum logic [1:0] {
    ST_RUN = 2'b01,
    ST_PAD = 2'b10
  } back_state_t;

  function automatic logic [CRC_W-1:0] fold_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [7:0] din);
    logic [CRC_W-1:0] c;
    c = crc ^ {24'd0, din};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/core/bcrc_front.sv
// bcrc_front: input queue, takes byte transactions and holds them for the crc engine
// depends on bcrc_pkg
module bcrc_front
  import bcrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output q_out_t     q_out,
  input  logic       q_take
);

  item_t           mem_r [QUEUE_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   count_r, count_nxt;
  logic            wr_en, rd_en;

  assign in_full     = (count_r == (Q_AW + 1)'(QUEUE_DEPTH));
  assign wr_en       = in_push && !in_full;
  assign rd_en       = q_take && (count_r != '0);
  assign q_out.valid = (count_r != '0);
  assign q_out.item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= '{data: in_data_byte, last: in_last_byte};
    end
  end

endmodule

>>> rtl/core/bcrc_back.sv
// bcrc_back: crc engine, zero padding sequencer and result register
// depends on bcrc_pkg
module bcrc_back
  import bcrc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  q_out_t           q_in,
  output logic             q_take,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [CRC_W-1:0] out_crc_word,
  output logic [BLK_W-1:0] out_block_number,
  output logic [PAD_W-1:0] out_padded_bytes,
  output logic             out_final_block
);

  back_state_t      state_r, state_nxt;
  logic [CRC_W-1:0] crc_r, crc_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] pad_r, pad_nxt;
  logic [BLK_W-1:0] blk_r, blk_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CRC_W-1:0] res_crc_r, res_crc_nxt;
  logic [BLK_W-1:0] res_blk_r, res_blk_nxt;
  logic [PAD_W-1:0] res_pad_r, res_pad_nxt;
  logic             res_fin_r, res_fin_nxt;

  logic [CRC_W-1:0] crc_f;
  logic [POS_W-1:0] pos_inc;
  logic             at_end;
  logic             slot_free;
  logic             emit;
  logic [31:0]      pad_wide;

  assign pos_inc   = pos_r + 1'b1;
  assign at_end    = (pos_inc == POS_W'(BLOCK_BYTES));
  assign slot_free = !out_valid_r || out_pop;
  assign pad_wide  = 32'(pad_r);
  assign crc_f     = fold_byte(crc_r, (state_r == ST_PAD) ? 8'd0 : q_in.item.data);

  always_comb begin
    state_nxt   = state_r;
    crc_nxt     = crc_r;
    pos_nxt     = pos_r;
    pad_nxt     = pad_r;
    blk_nxt     = blk_r;
    q_take      = 1'b0;
    emit        = 1'b0;
    res_crc_nxt = res_crc_r;
    res_blk_nxt = res_blk_r;
    res_pad_nxt = res_pad_r;
    res_fin_nxt = res_fin_r;
    case (state_r)
      ST_RUN: begin
        if (q_in.valid) begin
          if (at_end) begin
            if (slot_free) begin
              q_take      = 1'b1;
              emit        = 1'b1;
              res_crc_nxt = ~crc_f;
              res_blk_nxt = blk_r;
              res_pad_nxt = '0;
              res_fin_nxt = q_in.item.last;
              crc_nxt     = CRC_INIT;
              pos_nxt     = '0;
              blk_nxt     = blk_r + 1'b1;
            end
          end else begin
            q_take  = 1'b1;
            crc_nxt = crc_f;
            pos_nxt = pos_inc;
            if (q_in.item.last) begin
              pad_nxt   = POS_W'(BLOCK_BYTES) - pos_inc;
              state_nxt = ST_PAD;
            end
          end
        end
      end
      ST_PAD: begin
        if (at_end) begin
          if (slot_free) begin
            emit        = 1'b1;
            res_crc_nxt = ~crc_f;
            res_blk_nxt = blk_r;
            res_pad_nxt = (pad_wide > PAD_MAX) ? PAD_W'(PAD_MAX) : PAD_W'(pad_wide);
            res_fin_nxt = 1'b1;
            crc_nxt     = CRC_INIT;
            pos_nxt     = '0;
            blk_nxt     = blk_r + 1'b1;
            state_nxt   = ST_RUN;
          end
        end else begin
          crc_nxt = crc_f;
          pos_nxt = pos_inc;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      crc_r       <= CRC_INIT;
      pos_r       <= '0;
      pad_r       <= '0;
      blk_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      crc_r       <= crc_nxt;
      pos_r       <= pos_nxt;
      pad_r       <= pad_nxt;
      blk_r       <= blk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_crc_r <= res_crc_nxt;
    res_blk_r <= res_blk_nxt;
    res_pad_r <= res_pad_nxt;
    res_fin_r <= res_fin_nxt;
  end

  assign out_empty        = !out_valid_r;
  assign out_crc_word     = res_crc_r;
  assign out_block_number = res_blk_r;
  assign out_padded_bytes = res_pad_r;
  assign out_final_block  = res_fin_r;

endmodule

>>> rtl/core/block_crc32_with_zero_padding.sv
// block_crc32_with_zero_padding: top level of the per-block crc-32 core
// depends on bcrc_pkg, bcrc_front and bcrc_back
//
// usage
// - input channel: one image byte per transaction on in_data_byte, with
//   in_last_byte high on the final byte; taken when in_push is high and
//   in_full is low
// - result channel: one transaction per completed block (crc, block number,
//   zero padding count, final flag); valid while out_empty is low, taken
//   when out_pop is high
// - throughput: one byte per cycle, set by the single crc byte fold in the
//   engine, while the result register can take each finished block; a last
//   byte closing a partial block makes the engine fold one zero byte per cycle
//   until the block is full, taking no bytes meanwhile
// - a result is visible in the cycle after its block's final byte is folded
// - reset clears the queue, the crc, the byte position and the block counter
// - a stalled result waits in the result register; the engine keeps taking
//   bytes until it has another block to hand over, and the four entry input
//   queue then fills and raises in_full
module block_crc32_with_zero_padding
  import bcrc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic [7:0]       in_data_byte,
  input  logic             in_last_byte,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [CRC_W-1:0] out_crc_word,
  output logic [BLK_W-1:0] out_block_number,
  output logic [PAD_W-1:0] out_padded_bytes,
  output logic             out_final_block
);

  q_out_t q_link;
  logic   q_take;

  bcrc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_out        (q_link),
    .q_take       (q_take)
  );

  bcrc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_in             (q_link),
    .q_take           (q_take),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_crc_word     (out_crc_word),
    .out_block_number (out_block_number),
    .out_padded_bytes (out_padded_bytes),
    .out_final_block  (out_final_block)
  );

endmodule
